// File: src/dlr_pkg.sv
// Shared constants, types and controller/datapath command structs for the
// direct line rasterizer. No dependencies.
`timescale 1ns / 1ps

package dlr_pkg;

    localparam int COORD_BITS = 6;
    // signed endpoint difference
    localparam int DELTA_W    = COORD_BITS + 1;
    // twice a signed delta
    localparam int INC_W      = COORD_BITS + 2;
    // remainder plus increment
    localparam int SUM_W      = COORD_BITS + 3;
    // remainder and denominator, both below 2^(COORD_BITS+1)
    localparam int REM_W      = COORD_BITS + 1;

    typedef logic [COORD_BITS-1:0] t_coord;

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_RUN  = 2'b10
    } t_state;

    typedef struct packed {
        logic load;   // capture a segment and set up the stepper
        logic step;   // advance to the next pixel
    } t_dp_cmd;

    typedef struct packed {
        logic last;   // current pixel is the final one of the segment
    } t_dp_status;

endpackage

// File: src/dlr_if.sv
// Valid/ready channel interfaces for segments in and pixels out.
// Depends on dlr_pkg.
`timescale 1ns / 1ps

interface dlr_seg_if
    import dlr_pkg::*;
();
    logic   valid;
    logic   ready;
    t_coord start_x;
    t_coord start_y;
    t_coord end_x;
    t_coord end_y;

    modport source (output valid, output start_x, output start_y, output end_x,
                    output end_y, input ready);
    modport sink   (input valid, input start_x, input start_y, input end_x,
                    input end_y, output ready);
endinterface

interface dlr_pix_if
    import dlr_pkg::*;
();
    logic   valid;
    logic   ready;
    t_coord pixel_x;
    t_coord pixel_y;
    logic   last_pixel;

    modport source (output valid, output pixel_x, output pixel_y, output last_pixel,
                    input ready);
    modport sink   (input valid, input pixel_x, input pixel_y, input last_pixel,
                    output ready);
endinterface

// File: src/direct_line_rasterizer_core.sv
// Line rasterizer: takes one segment (two endpoints) on i_seg and emits its
// pixels one per item on o_pix, the final pixel flagged by last_pixel.
// A segment emits max(|dx|,|dy|)+1 pixels. Its first pixel is valid the
// cycle after the segment is taken; then one pixel per cycle while the
// receiver is ready. The controller returns to idle after the last pixel
// is taken, and only then accepts the next segment. Pixels come from a
// single stepper, which produces one pixel a cycle while the receiver is
// ready, using one add and at most one correction per step.
// Segments are handled one at a time: i_seg.ready is high only while no
// segment is in progress.
// When the receiver stalls, the current pixel holds on o_pix and the
// stepper waits. Synchronous active-low reset returns to idle with no
// pixel pending; nothing else needs clearing.
// Depends on dlr_pkg, dlr_if, dlr_ctrl and dlr_datapath.
`timescale 1ns / 1ps

module direct_line_rasterizer_core
    import dlr_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    dlr_seg_if.sink   i_seg,
    dlr_pix_if.source o_pix
);

    t_dp_cmd    w_cmd;
    t_dp_status w_status;
    t_coord     w_pixel_x, w_pixel_y;

    dlr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_seg.valid),
        .o_in_ready  (i_seg.ready),
        .o_out_valid (o_pix.valid),
        .i_out_ready (o_pix.ready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    dlr_datapath u_dp (
        .i_clk     (i_clk),
        .i_start_x (i_seg.start_x),
        .i_start_y (i_seg.start_y),
        .i_end_x   (i_seg.end_x),
        .i_end_y   (i_seg.end_y),
        .i_cmd     (w_cmd),
        .o_pixel_x (w_pixel_x),
        .o_pixel_y (w_pixel_y),
        .o_status  (w_status)
    );

    assign o_pix.pixel_x    = w_pixel_x;
    assign o_pix.pixel_y    = w_pixel_y;
    assign o_pix.last_pixel = w_status.last;

endmodule

// File: src/dlr_ctrl.sv
// Controller state machine: accepts a segment, then walks it pixel by pixel.
// Depends on dlr_pkg.
`timescale 1ns / 1ps

module dlr_ctrl
    import dlr_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    t_state r_state, n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = S_RUN;
                end
            end
            S_RUN: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    // drop back to idle after the final pixel, else advance
                    if (i_status.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.step = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// File: src/dlr_datapath.sv
// Segment setup and exact rounded slope stepper. The minor coordinate is
// kept as quotient plus remainder over 2*|major delta|. Depends on dlr_pkg.
`timescale 1ns / 1ps

module dlr_datapath
    import dlr_pkg::*;
(
    input  logic       i_clk,
    input  t_coord     i_start_x,
    input  t_coord     i_start_y,
    input  t_coord     i_end_x,
    input  t_coord     i_end_y,
    input  t_dp_cmd    i_cmd,
    output t_coord     o_pixel_x,
    output t_coord     o_pixel_y,
    output t_dp_status o_status
);

    // setup
    logic signed [DELTA_W-1:0] w_dx, w_dy, w_neg_dx, w_neg_dy, w_other;
    t_coord                    w_adx, w_ady, w_span, w_major0, w_minor0;
    logic                      w_ymaj, w_flip;

    // stepper
    logic signed [SUM_W-1:0]   w_sum, w_inc_ext, w_den_ext, w_sum_hi, w_sum_lo;

    t_coord                    r_major, r_minor, r_cnt;
    logic [REM_W-1:0]          r_rem, r_den;
    logic signed [INC_W-1:0]   r_inc;
    logic                      r_ymaj;

    always_comb begin
        w_dx     = signed'({1'b0, i_end_x}) - signed'({1'b0, i_start_x});
        w_dy     = signed'({1'b0, i_end_y}) - signed'({1'b0, i_start_y});
        w_neg_dx = -w_dx;
        w_neg_dy = -w_dy;
        w_adx    = w_dx[DELTA_W-1] ? w_neg_dx[COORD_BITS-1:0] : w_dx[COORD_BITS-1:0];
        w_ady    = w_dy[DELTA_W-1] ? w_neg_dy[COORD_BITS-1:0] : w_dy[COORD_BITS-1:0];
        // y is the major axis unless |dy| < |dx|; vertical and diagonal land here too
        w_ymaj   = !(w_ady < w_adx);
        w_flip   = w_ymaj ? w_dy[DELTA_W-1] : w_dx[DELTA_W-1];
        w_span   = w_ymaj ? w_ady : w_adx;
        if (w_ymaj) begin
            w_other  = w_flip ? w_neg_dx : w_dx;
            w_major0 = w_flip ? i_end_y : i_start_y;
            w_minor0 = w_flip ? i_end_x : i_start_x;
        end else begin
            w_other  = w_flip ? w_neg_dy : w_dy;
            w_major0 = w_flip ? i_end_x : i_start_x;
            w_minor0 = w_flip ? i_end_y : i_start_y;
        end
    end

    always_comb begin
        w_inc_ext = signed'({r_inc[INC_W-1], r_inc});
        w_den_ext = signed'({2'b00, r_den});
        w_sum     = signed'({2'b00, r_rem}) + w_inc_ext;
        w_sum_hi  = w_sum - w_den_ext;
        w_sum_lo  = w_sum + w_den_ext;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_major <= w_major0;
            r_minor <= w_minor0;
            r_cnt   <= w_span;
            r_rem   <= {1'b0, w_span};      // half-up rounding offset
            r_den   <= {w_span, 1'b0};
            r_inc   <= {w_other, 1'b0};
            r_ymaj  <= w_ymaj;
        end else if (i_cmd.step) begin
            r_major <= r_major + t_coord'(1);
            r_cnt   <= r_cnt - t_coord'(1);
            // one correction suffices since |inc| never exceeds the denominator
            if (w_sum >= w_den_ext) begin
                r_minor <= r_minor + t_coord'(1);
                r_rem   <= w_sum_hi[REM_W-1:0];
            end else if (w_sum < 0) begin
                r_minor <= r_minor - t_coord'(1);
                r_rem   <= w_sum_lo[REM_W-1:0];
            end else begin
                r_rem   <= w_sum[REM_W-1:0];
            end
        end
    end

    assign o_pixel_x     = r_ymaj ? r_minor : r_major;
    assign o_pixel_y     = r_ymaj ? r_major : r_minor;
    assign o_status.last = (r_cnt == '0);

endmodule

// File: src/dlr_checker.sv
// Port-level checks on the rasterizer's segment and pixel channels, bound
// to the top level. Depends on dlr_pkg.
`timescale 1ns / 1ps

module dlr_checker
    import dlr_pkg::*;
(
    input logic   i_clk,
    input logic   i_rst_n,
    input logic   i_in_valid,
    input logic   i_in_ready,
    input logic   i_out_valid,
    input logic   i_out_ready,
    input t_coord i_pixel_x,
    input t_coord i_pixel_y,
    input logic   i_last_pixel
);

    // a taken segment always shows its first pixel next cycle
    a_first_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && i_in_ready) |=> i_out_valid)
        else $error("no pixel after segment accept");

    // no new segment while pixels are pending
    a_one_segment: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_in_ready && i_out_valid))
        else $error("segment taken while pixels pending");

    // the segment keeps producing until its last pixel goes out
    a_continue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && !i_last_pixel) |=> i_out_valid)
        else $error("segment ended without last pixel");

    a_back_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && i_out_ready && i_last_pixel) |=> (i_in_ready && !i_out_valid))
        else $error("not idle after last pixel");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=>
            (i_out_valid && $stable(i_pixel_x) && $stable(i_pixel_y)
             && $stable(i_last_pixel)))
        else $error("stalled pixel changed");

endmodule

bind direct_line_rasterizer_core dlr_checker u_dlr_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_seg.valid),
    .i_in_ready   (i_seg.ready),
    .i_out_valid  (o_pix.valid),
    .i_out_ready  (o_pix.ready),
    .i_pixel_x    (o_pix.pixel_x),
    .i_pixel_y    (o_pix.pixel_y),
    .i_last_pixel (o_pix.last_pixel)
);

// File: tb/tb.sv
// Self-checking testbench for direct_line_rasterizer_core: drives segments, predicts
// every pixel in-line and compares each one as it leaves the block.
// Depends on dlr_pkg, the dlr_seg_if/dlr_pix_if interfaces and the core RTL.
`timescale 1ns / 1ps

module tb;
    import dlr_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int TAIL_CYCLES    = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int COORD_MAX      = (1 << COORD_BITS) - 1;

    typedef struct packed {
        t_coord x;
        t_coord y;
        logic   last;
    } t_pixel;

    logic i_clk;
    logic i_rst_n;

    dlr_seg_if seg_bus ();
    dlr_pix_if pix_bus ();

    direct_line_rasterizer_core u_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_seg   (seg_bus.sink),
        .o_pix   (pix_bus.source)
    );

    t_pixel pending_pixels[$];
    int     err_count;
    int     segments_sent;
    int     pixels_checked;
    int     idle_cycles;
    int     rx_hold_req;
    bit     rx_stall_en;
    bit     tx_gap_en;

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Rounded half up; numerator is always positive here.
    function automatic int round_half_up(int base, int other, int t, int span);
        return (2 * span * base + 2 * other * t + span) / (2 * span);
    endfunction

    function automatic void rasterize_segment(t_coord x1, t_coord y1, t_coord x2, t_coord y2);
        int     dx;
        int     dy;
        int     adx;
        int     ady;
        int     xa;
        int     ya;
        int     sdx;
        int     sdy;
        t_pixel pix;
        dx  = int'(x2) - int'(x1);
        dy  = int'(y2) - int'(y1);
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        if (dx == 0) begin
            ya = y1 < y2 ? int'(y1) : int'(y2);
            for (int t = 0; t <= ady; t++) begin
                pix.x    = x1;
                pix.y    = t_coord'(ya + t);
                pix.last = (t == ady);
                pending_pixels.push_back(pix);
            end
        end else if (ady < adx) begin
            // Step x from the left end.
            xa = x1; ya = y1; sdx = dx; sdy = dy;
            if (dx < 0) begin
                xa = x2; ya = y2; sdx = -dx; sdy = -dy;
            end
            for (int t = 0; t <= sdx; t++) begin
                pix.x    = t_coord'(xa + t);
                pix.y    = t_coord'(round_half_up(ya, sdy, t, sdx));
                pix.last = (t == sdx);
                pending_pixels.push_back(pix);
            end
        end else begin
            // Step y upward from the lower end; diagonals land here.
            xa = x1; ya = y1; sdx = dx; sdy = dy;
            if (dy < 0) begin
                xa = x2; ya = y2; sdx = -dx; sdy = -dy;
            end
            for (int t = 0; t <= sdy; t++) begin
                pix.x    = t_coord'(round_half_up(xa, sdx, t, sdy));
                pix.y    = t_coord'(ya + t);
                pix.last = (t == sdy);
                pending_pixels.push_back(pix);
            end
        end
    endfunction

    // Offer one segment and hold it until taken; returns at the accepting edge.
    task automatic send_segment(int x1, int y1, int x2, int y2);
        int gap;
        int roll;
        gap = 0;
        if (tx_gap_en) begin
            roll = $urandom_range(99);
            if (roll >= 95)
                gap = $urandom_range(40, 10);
            else if (roll >= 65)
                gap = $urandom_range(3, 1);
        end
        if (gap > 0) begin
            seg_bus.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        seg_bus.valid   <= 1'b1;
        seg_bus.start_x <= t_coord'(x1);
        seg_bus.start_y <= t_coord'(y1);
        seg_bus.end_x   <= t_coord'(x2);
        seg_bus.end_y   <= t_coord'(y2);
        @(posedge i_clk);
        while (!seg_bus.ready) @(posedge i_clk);
        rasterize_segment(t_coord'(x1), t_coord'(y1), t_coord'(x2), t_coord'(y2));
        segments_sent++;
    endtask

    task automatic wait_all_pixels();
        seg_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
    endtask

    task automatic send_random_segment();
        int roll;
        int x1;
        int y1;
        int x2;
        int y2;
        roll = $urandom_range(99);
        x1 = $urandom_range(COORD_MAX);
        y1 = $urandom_range(COORD_MAX);
        x2 = $urandom_range(COORD_MAX);
        y2 = $urandom_range(COORD_MAX);
        if (roll < 30) begin
            // short segment near the first endpoint
            x2 = x1 + $urandom_range(8) - 4;
            y2 = y1 + $urandom_range(8) - 4;
            x2 = x2 < 0 ? 0 : (x2 > COORD_MAX ? COORD_MAX : x2);
            y2 = y2 < 0 ? 0 : (y2 > COORD_MAX ? COORD_MAX : y2);
        end else if (roll < 38) begin
            x2 = x1;
        end else if (roll < 46) begin
            y2 = y1;
        end else if (roll < 54) begin
            // diagonal, clipped to the grid
            y2 = (y1 + (x2 - x1) > COORD_MAX || y1 + (x2 - x1) < 0) ? y1 - (x2 - x1)
                                                                    : y1 + (x2 - x1);
            if (y2 < 0 || y2 > COORD_MAX) begin
                x2 = x1;
                y2 = y1;
            end
        end else if (roll < 60) begin
            x2 = x1;
            y2 = y1;
        end
        send_segment(x1, y1, x2, y2);
    endtask

    task automatic test_directed();
        send_segment(0, 0, 0, 0);
        send_segment(63, 63, 63, 63);
        send_segment(5, 0, 5, 63);
        send_segment(63, 63, 63, 0);
        send_segment(0, 10, 63, 10);
        send_segment(63, 0, 0, 0);
        send_segment(0, 0, 63, 63);
        send_segment(0, 63, 63, 0);
        send_segment(63, 63, 0, 0);
        send_segment(0, 0, 2, 1);
        send_segment(0, 0, 1, 2);
        send_segment(2, 1, 0, 0);
        send_segment(2, 0, 0, 1);
        send_segment(1, 2, 0, 0);
        send_segment(0, 0, 63, 1);
        send_segment(0, 0, 1, 63);
        send_segment(63, 0, 0, 62);
        send_segment(10, 20, 30, 25);
        send_segment(42, 21, 21, 42);
        send_segment(0, 63, 63, 63);
        wait_all_pixels();
    endtask

    task automatic test_random_traffic(int count);
        rx_stall_en = 1'b1;
        tx_gap_en   = 1'b1;
        for (int i = 0; i < count; i++) begin
            send_random_segment();
            if ($urandom_range(49) == 0)
                wait_all_pixels();
        end
        wait_all_pixels();
    endtask

    task automatic test_back_to_back(int count);
        rx_stall_en = 1'b0;
        tx_gap_en   = 1'b0;
        for (int i = 0; i < count; i++)
            send_random_segment();
        wait_all_pixels();
    endtask

    task automatic test_output_hold(int count);
        rx_stall_en = 1'b1;
        tx_gap_en   = 1'b0;
        rx_hold_req = HOLD_CYCLES;
        for (int i = 0; i < count; i++)
            send_random_segment();
        wait_all_pixels();
    endtask

    // Receiver: random stalls, mostly short, plus a long hold on request.
    initial begin
        int stall_left;
        int roll;
        stall_left    = 0;
        pix_bus.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (rx_hold_req > 0) begin
                pix_bus.ready <= 1'b0;
                rx_hold_req--;
            end else if (stall_left > 0) begin
                pix_bus.ready <= 1'b0;
                stall_left--;
            end else begin
                pix_bus.ready <= 1'b1;
                if (rx_stall_en && $urandom_range(99) < 20) begin
                    roll = $urandom_range(99);
                    stall_left = (roll < 90) ? $urandom_range(3, 1) : $urandom_range(40, 10);
                end
            end
        end
    end

    // Compare each pixel taken from the block with the oldest prediction.
    always @(posedge i_clk) begin
        t_pixel exp_pix;
        if (i_rst_n && pix_bus.valid && pix_bus.ready) begin
            if (pending_pixels.size() == 0) begin
                $error("unexpected pixel x=%0d y=%0d last=%0d",
                       pix_bus.pixel_x, pix_bus.pixel_y, pix_bus.last_pixel);
                err_count++;
            end else begin
                exp_pix = pending_pixels.pop_front();
                pixels_checked++;
                if (pix_bus.pixel_x !== exp_pix.x) begin
                    $error("pixel_x expected %0d actual %0d", exp_pix.x, pix_bus.pixel_x);
                    err_count++;
                end
                if (pix_bus.pixel_y !== exp_pix.y) begin
                    $error("pixel_y expected %0d actual %0d", exp_pix.y, pix_bus.pixel_y);
                    err_count++;
                end
                if (pix_bus.last_pixel !== exp_pix.last) begin
                    $error("last_pixel expected %0d actual %0d",
                           exp_pix.last, pix_bus.last_pixel);
                    err_count++;
                end
            end
        end
    end

    // Abort when nothing moves on either channel for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (seg_bus.valid && seg_bus.ready) || (pix_bus.valid && pix_bus.ready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else
            idle_cycles <= idle_cycles + 1;
    end

    initial begin
        err_count       = 0;
        segments_sent   = 0;
        pixels_checked  = 0;
        idle_cycles     = 0;
        rx_hold_req     = 0;
        rx_stall_en     = 1'b1;
        tx_gap_en       = 1'b1;
        i_rst_n         = 1'b0;
        seg_bus.valid   = 1'b0;
        seg_bus.start_x = '0;
        seg_bus.start_y = '0;
        seg_bus.end_x   = '0;
        seg_bus.end_y   = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_random_traffic(200);
        test_back_to_back(40);
        test_output_hold(40);

        seg_bus.valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        $display("Ran %0d segments (directed edges, ties, diagonals, random mix)", segments_sent);
        $display("Checked %0d pixels under random stalls and a long output hold",
                 pixels_checked);
        if (err_count == 0 && pending_pixels.size() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
